### hdl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the byte ring buffer: operation codes,
// stream field widths and the controller command bundle.
// ----------------------------------------------------------------------------
package brf_pkg;

    // operation codes carried in the op field
    localparam logic [2:0] OP_PUSH     = 3'd0;
    localparam logic [2:0] OP_POP      = 3'd1;
    localparam logic [2:0] OP_PEEK     = 3'd2;
    localparam logic [2:0] OP_ADV_HEAD = 3'd3;
    localparam logic [2:0] OP_ADV_TAIL = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    // field widths
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int AMT_W   = 14;
    localparam int CNT_W   = 14;
    localparam int CAPCFG_W = 15;

    // stream and configuration bus widths (whole bytes)
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_DATA_W  = 16;

    // capacity after reset
    localparam int CAP_RESET = 10000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_item;   // latch the accepted request
        logic exec;        // apply the operation, access the byte memory
        logic load_out;    // capture the result into the output register
        logic cfg_write;   // write the capacity register, empty the buffer
    } brf_cmd_t;

endpackage

### hdl/brf_datapath.sv
// ----------------------------------------------------------------------------
// brf_datapath
// Byte memory, head/tail pointers, capacity register and result register of
// the byte ring buffer, stepped by commands from the controller.
// ----------------------------------------------------------------------------
module brf_datapath #(
    parameter int DEPTH = 16384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  brf_pkg::brf_cmd_t                cmd,
    input  logic [brf_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [brf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [brf_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int SW = ((CW > brf_pkg::AMT_W) ? CW : brf_pkg::AMT_W) + 1;
    localparam int CAP_INIT = (brf_pkg::CAP_RESET > DEPTH) ? DEPTH : brf_pkg::CAP_RESET;
    localparam int RES_W = brf_pkg::BYTE_W + 1 + 4 * brf_pkg::CNT_W;
    localparam int PAD_W = brf_pkg::OUT_TDATA_W - RES_W;

    // pointer and capacity state
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cap_reg, cap_next;

    // latched request
    logic [brf_pkg::OP_W-1:0]   op_reg;
    logic [brf_pkg::BYTE_W-1:0] din_reg;
    logic [brf_pkg::AMT_W-1:0]  amt_reg;

    // operation outcome
    logic                       ok_reg, ok_next;
    logic                       rd_sel_reg, rd_sel_next;
    logic [brf_pkg::BYTE_W-1:0] rd_data_reg;

    // byte memory
    logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;

    // result register
    logic [RES_W-1:0] res_reg;

    // wrap-around add, operands keep the sum below twice the capacity
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                               input logic [SW-1:0] n,
                                               input logic [CW-1:0] cap);
        logic [SW-1:0] s;
        s = SW'(p) + n;
        if (s >= SW'(cap))
            s = s - SW'(cap);
        return AW'(s);
    endfunction

    // stored byte count
    function automatic logic [CW-1:0] used_of(input logic [AW-1:0] h,
                                              input logic [AW-1:0] t,
                                              input logic [CW-1:0] cap);
        logic [CW-1:0] u;
        if (t >= h)
            u = CW'(t) - CW'(h);
        else
            u = cap - CW'(h) + CW'(t);
        return u;
    endfunction

    // clamp of the written capacity
    logic [31:0] cfg_val;
    logic [31:0] cfg_clamped;

    always_comb
    begin
        cfg_val = 32'(cfg_data[brf_pkg::CAPCFG_W-1:0]);
        if (cfg_val < 32'd2)
            cfg_clamped = 32'd2;
        else if (cfg_val > 32'(DEPTH))
            cfg_clamped = 32'(DEPTH);
        else
            cfg_clamped = cfg_val;
    end

    // operation decode and pointer update
    logic [CW-1:0] used_pre;
    logic [CW-1:0] free_pre;
    logic          at_tail;
    logic [AW-1:0] wrap_base;
    logic [SW-1:0] wrap_n;
    logic [AW-1:0] wrap_sum;
    logic          amt_lt_cap;

    always_comb
    begin
        used_pre   = used_of(head_reg, tail_reg, cap_reg);
        free_pre   = cap_reg - used_pre - CW'(1);
        at_tail    = (op_reg == brf_pkg::OP_PUSH) || (op_reg == brf_pkg::OP_ADV_TAIL);
        wrap_base  = at_tail ? tail_reg : head_reg;
        wrap_n     = ((op_reg == brf_pkg::OP_PUSH) || (op_reg == brf_pkg::OP_POP))
                     ? SW'(1) : SW'(amt_reg);
        wrap_sum   = wrap_add(wrap_base, wrap_n, cap_reg);
        amt_lt_cap = SW'(amt_reg) < SW'(cap_reg);

        head_next   = head_reg;
        tail_next   = tail_reg;
        cap_next    = cap_reg;
        ok_next     = 1'b0;
        rd_sel_next = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = (op_reg == brf_pkg::OP_PEEK) ? wrap_sum : head_reg;

        if (cmd.cfg_write)
        begin
            cap_next  = CW'(cfg_clamped);
            head_next = '0;
            tail_next = '0;
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                brf_pkg::OP_PUSH:
                begin
                    if (free_pre != '0)
                    begin
                        ok_next   = 1'b1;
                        wr_en     = 1'b1;
                        tail_next = wrap_sum;
                    end
                end
                brf_pkg::OP_POP:
                begin
                    if (used_pre != '0)
                    begin
                        ok_next     = 1'b1;
                        rd_sel_next = 1'b1;
                        head_next   = wrap_sum;
                    end
                end
                brf_pkg::OP_PEEK:
                begin
                    if (SW'(amt_reg) < SW'(used_pre))
                    begin
                        ok_next     = 1'b1;
                        rd_sel_next = 1'b1;
                    end
                end
                brf_pkg::OP_ADV_HEAD:
                begin
                    if (amt_lt_cap)
                    begin
                        ok_next   = 1'b1;
                        head_next = wrap_sum;
                    end
                end
                brf_pkg::OP_ADV_TAIL:
                begin
                    if (amt_lt_cap)
                    begin
                        ok_next   = 1'b1;
                        tail_next = wrap_sum;
                    end
                end
                brf_pkg::OP_CLEAR:
                begin
                    ok_next   = 1'b1;
                    head_next = '0;
                    tail_next = '0;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // pointer and capacity registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cap_reg  <= CW'(CAP_INIT);
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cap_reg  <= cap_next;
        end
    end

    // request latch and outcome flags
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            op_reg  <= s_tdata[2:0];
            din_reg <= s_tdata[10:3];
            amt_reg <= s_tdata[24:11];
        end
        if (cmd.exec)
        begin
            ok_reg     <= ok_next;
            rd_sel_reg <= rd_sel_next;
        end
    end

    // byte memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[tail_reg] <= din_reg;
        if (cmd.exec)
            rd_data_reg <= mem[rd_addr];
    end

    // counts after the operation
    logic [CW-1:0] used_post;
    logic [CW-1:0] free_post;
    logic [CW-1:0] cw_post;
    logic [CW-1:0] cr_post;
    logic [brf_pkg::BYTE_W-1:0] dout;

    always_comb
    begin
        used_post = used_of(head_reg, tail_reg, cap_reg);
        free_post = cap_reg - used_post - CW'(1);

        if (head_reg > tail_reg)
            cw_post = CW'(head_reg) - CW'(tail_reg) - CW'(1);
        else if (head_reg == '0)
            cw_post = cap_reg - CW'(tail_reg) - CW'(1);
        else
            cw_post = cap_reg - CW'(tail_reg);

        if (head_reg == tail_reg)
            cr_post = '0;
        else if (head_reg > tail_reg)
            cr_post = cap_reg - CW'(head_reg);
        else
            cr_post = CW'(tail_reg) - CW'(head_reg);

        dout = rd_sel_reg ? rd_data_reg : '0;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            res_reg <= {brf_pkg::CNT_W'(cr_post), brf_pkg::CNT_W'(cw_post),
                        brf_pkg::CNT_W'(free_post), brf_pkg::CNT_W'(used_post),
                        ok_reg, dout};
    end

    assign m_tdata = {{PAD_W{1'b0}}, res_reg};

endmodule

### hdl/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl
// Controller of the byte ring buffer: sequences accept, execute and result
// capture of one request and drives the stream and configuration handshakes.
// ----------------------------------------------------------------------------
module brf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output brf_pkg::brf_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_free       = !out_valid_reg || m_tready;
        cmd            = '0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.cfg_write = cfg_valid;
                if (s_tvalid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

endmodule

### hdl/byte_ring_fifo_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_unit
// Byte ring buffer with a programmable capacity, one slot always kept empty.
// ----------------------------------------------------------------------------
// Each request carries one operation (push, pop, peek at an offset past the
// head, advance head, advance tail, clear) and yields exactly one result with
// the byte read, an ok flag and the used, free, contiguous-write and
// contiguous-read counts after the operation. A request is latched, then the
// pointers are updated together with the byte memory access, then the result
// is captured; a new request is accepted only once the previous result is
// captured. The request latch and the registered read port of the byte memory
// give these steps. A finished result waits in the output register while the
// next request is accepted; a stalled result holds the following request in
// capture. Writing the capacity register empties the buffer; values below 2
// act as 2 and values above DEPTH act as DEPTH. The byte memory needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module byte_ring_fifo_unit #(
    parameter int DEPTH = 16384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // op [2:0], data_in [10:3], amount [24:11]
    input  logic [brf_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // data_out [7:0], ok [8], used_count [22:9], free_count [36:23],
    // contig_write [50:37], contig_read [64:51]
    output logic [brf_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // capacity [14:0]
    input  logic [brf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready
);

    brf_pkg::brf_cmd_t cmd;

    // sequencing of requests
    brf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // pointers, byte memory and result register
    brf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata)
    );

endmodule
